>>> hw/rtl/assert_macros.svh
// -----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the RTL.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

>>> hw/rtl/swrm_pkg.sv
// -----------------------------------------------------------------------------
// Sliding-window RMS meter package
// Widths, reset constants, controller states and the command bundle.
// -----------------------------------------------------------------------------
package swrm_pkg;

  localparam int SAMPLE_BITS    = 16;
  localparam int LEVEL_W        = 16;
  localparam int CFG_W          = 13;
  localparam int WINDOW_MAX_DEF = 4096;

  localparam logic [CFG_W-1:0]   CFG_RESET = 13'd4096;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX = 16'hFFFF;

  // Square of a sample needs one bit less than twice the sample width.
  localparam int SQ_W = 2 * SAMPLE_BITS - 1;

  function automatic int sum_w(input int wmax);
    return SQ_W + $clog2(wmax);
  endfunction

  function automatic int root_w(input int wmax);
    return (sum_w(wmax) + 1) / 2;
  endfunction

  function automatic int addr_w(input int wmax);
    return (wmax > 1) ? $clog2(wmax) : 1;
  endfunction

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SQOLD,
    ST_SUB,
    ST_DIV,
    ST_ROOT,
    ST_OUT
  } swrm_state_t;

  typedef struct packed {
    logic accept;
    logic mem_rw;
    logic sq_old;
    logic sub;
    logic div_step;
    logic root_step;
    logic out_load;
  } swrm_cmd_t;

endpackage

>>> hw/rtl/swrm_ctrl.sv
// -----------------------------------------------------------------------------
// Sliding-window RMS meter controller
// Sequences ring update, square sum, serial divide and serial root per item.
// -----------------------------------------------------------------------------
module swrm_ctrl #(
  parameter int WINDOW_MAX = swrm_pkg::WINDOW_MAX_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output swrm_pkg::swrm_cmd_t cmd
);
  import swrm_pkg::*;

  localparam int ROOT_W = root_w(WINDOW_MAX);
  localparam int QW     = 2 * ROOT_W;
  localparam int ITER_W = $clog2(QW);

  swrm_state_t       state_r, state_nxt;
  logic [ITER_W-1:0] iter_r, iter_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  // Next state and iteration count.
  always_comb begin
    state_nxt = state_r;
    iter_nxt  = iter_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ:  state_nxt = ST_SQOLD;
      ST_SQOLD: state_nxt = ST_SUB;
      ST_SUB: begin
        state_nxt = ST_DIV;
        iter_nxt  = '0;
      end
      ST_DIV: begin
        if (iter_r == ITER_W'(QW - 1)) begin
          state_nxt = ST_ROOT;
          iter_nxt  = '0;
        end else begin
          iter_nxt = iter_r + 1'b1;
        end
      end
      ST_ROOT: begin
        if (iter_r == ITER_W'(ROOT_W - 1)) begin
          state_nxt = ST_OUT;
          iter_nxt  = '0;
        end else begin
          iter_nxt = iter_r + 1'b1;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Commands and handshake outputs.
  always_comb begin
    cmd           = '0;
    in_ready      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      ST_READ:  cmd.mem_rw    = 1'b1;
      ST_SQOLD: cmd.sq_old    = 1'b1;
      ST_SUB:   cmd.sub       = 1'b1;
      ST_DIV:   cmd.div_step  = 1'b1;
      ST_ROOT:  cmd.root_step = 1'b1;
      ST_OUT: begin
        if (out_free) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
        end
      end
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      iter_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      iter_r      <= iter_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> hw/rtl/swrm_dpath.sv
// -----------------------------------------------------------------------------
// Sliding-window RMS meter datapath
// Sample ring, running square sum, bit-serial divider and bit-serial root.
// -----------------------------------------------------------------------------
module swrm_dpath #(
  parameter int WINDOW_MAX = swrm_pkg::WINDOW_MAX_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  swrm_pkg::swrm_cmd_t               cmd,
  input  logic                              cfg_we,
  input  logic [swrm_pkg::CFG_W-1:0]        cfg_data,
  input  logic [swrm_pkg::SAMPLE_BITS-1:0]  in_sample,
  output logic [swrm_pkg::LEVEL_W-1:0]      level
);
  import swrm_pkg::*;

  localparam int ADDR_W = addr_w(WINDOW_MAX);
  localparam int CNT_W  = $clog2(WINDOW_MAX + 1);
  localparam int SUM_W  = sum_w(WINDOW_MAX);
  localparam int ROOT_W = root_w(WINDOW_MAX);
  localparam int QW     = 2 * ROOT_W;
  localparam int SREM_W = ROOT_W + 2;
  localparam int RT_W   = SREM_W + 3;

  // Control state.
  logic [CFG_W-1:0]  wl_r;
  logic [ADDR_W-1:0] wp_r;
  logic [CNT_W-1:0]  hwm_r;
  logic              full_r;
  logic [SUM_W-1:0]  sum_r;

  // Per-item working registers.
  logic signed [SAMPLE_BITS-1:0] sample_r;
  logic signed [SAMPLE_BITS-1:0] rd_r;
  logic                          old_valid_r;
  logic [ADDR_W-1:0]             pos_r;
  logic [CNT_W-1:0]              len_r;
  logic [CNT_W-1:0]              count_r;
  logic [SQ_W-1:0]               mul_r;
  logic [CNT_W-1:0]              rem_r;
  logic [QW-1:0]                 q_r;
  logic [SREM_W-1:0]             srem_r;
  logic [ROOT_W-1:0]             root_r;
  logic [LEVEL_W-1:0]            level_r;

  logic signed [SAMPLE_BITS-1:0] ring [WINDOW_MAX];

  logic [CNT_W-1:0]              len_eff;
  logic [ADDR_W-1:0]             pos_eff;
  logic [CNT_W-1:0]              pos_inc;
  logic                          wrap;
  logic signed [SAMPLE_BITS-1:0] old_val;
  logic signed [SAMPLE_BITS-1:0] mul_op;
  logic signed [2*SAMPLE_BITS-1:0] prod;
  logic [SUM_W-1:0]              diff;
  logic [CNT_W:0]                div_cat;
  logic [CNT_W+1:0]              div_trial;
  logic                          div_ok;
  logic [SREM_W+1:0]             rt_cat;
  logic [RT_W-1:0]               rt_trial;
  logic                          rt_ok;

  always_comb begin
    if (wl_r == '0) begin
      len_eff = CNT_W'(1);
    end else if (32'(wl_r) > WINDOW_MAX) begin
      len_eff = CNT_W'(WINDOW_MAX);
    end else begin
      len_eff = CNT_W'(wl_r);
    end
  end

  // A position left beyond a shortened window starts over at slot zero.
  assign pos_eff = (CNT_W'(wp_r) >= len_eff) ? '0 : wp_r;
  assign pos_inc = CNT_W'(pos_r) + 1'b1;
  assign wrap    = pos_inc >= len_r;

  // Slots are written in order from zero, so anything at or above the
  // fill mark has never been written and is read as zero.
  assign old_val = old_valid_r ? rd_r : '0;
  assign mul_op  = cmd.sq_old ? old_val : sample_r;
  assign prod    = (2*SAMPLE_BITS)'(mul_op) * (2*SAMPLE_BITS)'(mul_op);

  // The new square is added before the old one is removed; the sum wraps
  // modulo its width in between and ends exact.
  assign diff = sum_r - SUM_W'(mul_r);

  assign div_cat   = {rem_r, q_r[QW-1]};
  assign div_trial = {1'b0, div_cat} - {2'b00, count_r};
  assign div_ok    = !div_trial[CNT_W+1];

  assign rt_cat   = {srem_r, q_r[QW-1 -: 2]};
  assign rt_trial = {1'b0, rt_cat} - RT_W'({root_r, 2'b01});
  assign rt_ok    = !rt_trial[RT_W-1];

  assign level = level_r;

  always_ff @(posedge clk) begin
    if (cmd.mem_rw) begin
      rd_r        <= ring[pos_r];
      ring[pos_r] <= sample_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wl_r   <= CFG_RESET;
      wp_r   <= '0;
      hwm_r  <= '0;
      full_r <= 1'b0;
      sum_r  <= '0;
    end else begin
      if (cfg_we) begin
        wl_r <= cfg_data;
      end
      if (cmd.mem_rw) begin
        wp_r   <= wrap ? '0 : ADDR_W'(pos_inc);
        full_r <= full_r | wrap;
        if (pos_inc > hwm_r) begin
          hwm_r <= pos_inc;
        end
      end
      if (cmd.sq_old) begin
        sum_r <= sum_r + SUM_W'(mul_r);
      end
      if (cmd.sub) begin
        sum_r <= diff;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      sample_r <= in_sample;
      pos_r    <= pos_eff;
      len_r    <= len_eff;
    end
    if (cmd.mem_rw) begin
      old_valid_r <= CNT_W'(pos_r) < hwm_r;
      count_r     <= (full_r || wrap) ? len_r : pos_inc;
      mul_r       <= prod[SQ_W-1:0];
    end
    if (cmd.sq_old) begin
      mul_r <= prod[SQ_W-1:0];
    end
    if (cmd.sub) begin
      q_r    <= QW'(diff);
      rem_r  <= '0;
      srem_r <= '0;
      root_r <= '0;
    end
    if (cmd.div_step) begin
      q_r <= {q_r[QW-2:0], div_ok};
      if (div_ok) begin
        rem_r <= div_trial[CNT_W-1:0];
      end else begin
        rem_r <= div_cat[CNT_W-1:0];
      end
    end
    if (cmd.root_step) begin
      q_r <= {q_r[QW-3:0], 2'b00};
      if (rt_ok) begin
        srem_r <= rt_trial[SREM_W-1:0];
        root_r <= {root_r[ROOT_W-2:0], 1'b1};
      end else begin
        srem_r <= rt_cat[SREM_W-1:0];
        root_r <= {root_r[ROOT_W-2:0], 1'b0};
      end
    end
    if (cmd.out_load) begin
      level_r <= (root_r > ROOT_W'(LEVEL_MAX)) ? LEVEL_MAX : root_r[LEVEL_W-1:0];
    end
  end

endmodule

>>> hw/rtl/sliding_window_rms_meter.sv
// Sliding-window RMS meter: each accepted item is one signed 16-bit sample and
// yields one item carrying floor(sqrt(floor(sum of squares / count))) over the
// last window_length samples (fewer until the window has filled once). One item
// is handled at a time, and the next one is not taken until the previous one
// has passed through the bit-serial divider (one quotient bit per clock), the
// bit-serial square root (one root bit per clock) and into the output register.
// A finished level waits in that output register, so the next sample is
// accepted while it is still pending. The sample ring needs no clearing pass
// after reset: a fill mark tells which slots have never been written, and those
// are read as zero. The user must see that window_length is written through the
// cfg port only while the meter is idle; the block itself does not enforce it.
// A change takes effect from the next accepted sample; squares already summed stay.
// -----------------------------------------------------------------------------
// Sliding-window RMS meter top level
// Joins the controller and the datapath and exposes the stream ports.
// -----------------------------------------------------------------------------
`include "assert_macros.svh"

module sliding_window_rms_meter #(
  parameter int WINDOW_MAX = swrm_pkg::WINDOW_MAX_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [swrm_pkg::SAMPLE_BITS-1:0]  in_tdata,   // [15:0] audio_sample
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [swrm_pkg::LEVEL_W-1:0]      out_tdata,  // [15:0] rms_level
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [swrm_pkg::CFG_W-1:0]        cfg_data    // [12:0] window_length
);
  import swrm_pkg::*;

  swrm_cmd_t cmd;

  assign cfg_ready = 1'b1;

  swrm_ctrl #(
    .WINDOW_MAX (WINDOW_MAX)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .cmd       (cmd)
  );

  swrm_dpath #(
    .WINDOW_MAX (WINDOW_MAX)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .in_sample (in_tdata),
    .level     (out_tdata)
  );

  `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_tvalid && in_tready, !in_tready)
  `ASSERT_IMPLIES(a_ring_after_accept, clk, rst_n, cmd.mem_rw, $past(in_tvalid && in_tready))
  `ASSERT_NEXT(a_load_shows_level, clk, rst_n, cmd.out_load, out_tvalid && in_tready)
  `ASSERT_IMPLIES(a_one_command, clk, rst_n, 1'b1, $onehot0(cmd))

endmodule

>>> verif/tb.sv
// -----------------------------------------------------------------------------
// Sliding-window RMS meter testbench
// Streams signed samples into the meter and checks every level it returns
// against a predictor that keeps its own sample ring and sum of squares. A
// short directed table covers the full-scale samples, window lengths zero, one
// and sixteen, and saturation on stale ring entries. Random segments with
// several window settings (one above the maximum) and idle patterns follow.
// -----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import swrm_pkg::*;

  localparam int RING_DEPTH   = WINDOW_MAX_DEF;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 100;
  localparam int RESET_CYCLES = 10;

  // Idle percentages for the three traffic phases.
  localparam int IDLE_LIGHT = 18;
  localparam int IDLE_HEAVY = 78;
  localparam int IDLE_NONE  = 0;

  // Window choices for the random segments.
  localparam int WIN_RANDOM_SMALL = -1;
  localparam int WIN_RANDOM_ANY   = -2;
  localparam int NUM_SEGMENTS     = 8;

  typedef enum logic {ROW_SAMPLE, ROW_WINDOW} row_kind_t;

  typedef struct packed {
    row_kind_t       kind;
    logic [15:0]     value;
    logic            fixed;
    logic [LEVEL_W-1:0] level;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [SAMPLE_BITS-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [LEVEL_W-1:0] out_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_W-1:0] cfg_data = '0;

  int send_idle_pct = IDLE_LIGHT;
  int recv_idle_pct = IDLE_HEAVY;
  int fails = 0;
  int quiet_cycles = 0;

  // Predictor state.
  logic signed [SAMPLE_BITS-1:0] ring_copy [RING_DEPTH];
  int unsigned write_slot = 0;
  bit ring_wrapped = 1'b0;
  longint unsigned square_total = 0;
  logic [CFG_W-1:0] window_setting = CFG_RESET;

  logic [LEVEL_W-1:0] pending_levels [$];

  sliding_window_rms_meter uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always #6 clk = ~clk;

  function automatic longint unsigned square_mag(logic signed [SAMPLE_BITS-1:0] s);
    longint signed v;
    v = longint'(s);
    return longint'(v * v);
  endfunction

  // Bit-by-bit root: keep a candidate bit whenever its square still fits.
  function automatic logic [31:0] floor_root(longint unsigned v);
    logic [31:0] r;
    longint unsigned t;
    r = '0;
    for (int b = 31; b >= 0; b--) begin
      t = {32'b0, r} | (64'd1 << b);
      if (t * t <= v) r = t[31:0];
    end
    return r;
  endfunction

  function automatic logic [LEVEL_W-1:0] next_rms_level(logic [SAMPLE_BITS-1:0] raw);
    int unsigned len;
    int unsigned slot;
    int unsigned count;
    logic signed [SAMPLE_BITS-1:0] s;
    logic [31:0] root;
    s = $signed(raw);
    len = 32'(window_setting);
    if (len == 0) len = 1;
    if (len > RING_DEPTH) len = RING_DEPTH;
    slot = write_slot;
    if (slot >= len) slot = 0;
    square_total = square_total - square_mag(ring_copy[slot]) + square_mag(s);
    ring_copy[slot] = s;
    slot++;
    if (slot >= len) begin
      slot = 0;
      ring_wrapped = 1'b1;
    end
    write_slot = slot;
    count = ring_wrapped ? len : slot;
    if (count == 0) count = 1;
    root = floor_root(square_total / count);
    return (root > 32'(LEVEL_MAX)) ? LEVEL_MAX : root[LEVEL_W-1:0];
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] random_sample();
    int k;
    int m;
    k = $urandom_range(9);
    if (k < 3) return 16'($urandom());
    if (k == 3) begin
      case ($urandom_range(4))
        0: return 16'h8000;
        1: return 16'h7FFF;
        2: return 16'h0000;
        3: return 16'hFFFF;
        default: return 16'h0001;
      endcase
    end
    if (k < 6) return 16'($urandom_range(64) - 32);
    // Loud content near full scale, either sign.
    m = $urandom_range(32767, 16384);
    return $urandom_range(1) ? 16'(-m) : 16'(m);
  endfunction

  // Holds the sample until it is taken; valid stays high for a back-to-back item.
  task automatic push_sample(logic [SAMPLE_BITS-1:0] v, logic fixed,
                             logic [LEVEL_W-1:0] level);
    logic [LEVEL_W-1:0] predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= v;
    do @(posedge clk); while (!in_tready);
    predicted = next_rms_level(v);
    pending_levels.push_back(fixed ? level : predicted);
  endtask

  // The window is only changed once every level in flight has come back.
  task automatic write_window(logic [CFG_W-1:0] w);
    in_tvalid <= 1'b0;
    while (pending_levels.size() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= w;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    window_setting = w;
  endtask

  // Result side: random back-pressure and the level check.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_levels.size() == 0) begin
        $error("rms_level: item with no level expected, actual %0d", out_tdata);
        fails++;
      end else begin
        if (out_tdata !== pending_levels[0]) begin
          $error("rms_level: expected %0d, actual %0d", pending_levels[0], out_tdata);
          fails++;
        end
        void'(pending_levels.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
      $display("tb failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    row_t rows [28];
    int seg_win [NUM_SEGMENTS];
    int seg_cnt [NUM_SEGMENTS];
    int w;

    for (int i = 0; i < RING_DEPTH; i++) ring_copy[i] = '0;

    // Full-scale negative samples at reset give exactly 32768. Window zero acts
    // as one. Sixteen full-scale samples fill a 16 window, and shrinking it to one
    // leaves stale squares that push the level past 16 bits.
    rows[0]  = '{ROW_SAMPLE, 16'h8000, 1'b1, 16'd32768};
    rows[1]  = '{ROW_SAMPLE, 16'h8000, 1'b1, 16'd32768};
    rows[2]  = '{ROW_SAMPLE, 16'h7FFF, 1'b0, 16'd0};
    rows[3]  = '{ROW_SAMPLE, 16'h0000, 1'b0, 16'd0};
    rows[4]  = '{ROW_SAMPLE, 16'h0001, 1'b0, 16'd0};
    rows[5]  = '{ROW_SAMPLE, 16'hFFFF, 1'b0, 16'd0};
    rows[6]  = '{ROW_WINDOW, 16'd0,    1'b0, 16'd0};
    rows[7]  = '{ROW_SAMPLE, 16'h3039, 1'b0, 16'd0};
    rows[8]  = '{ROW_SAMPLE, 16'hCFC7, 1'b0, 16'd0};
    rows[9]  = '{ROW_WINDOW, 16'd16,   1'b0, 16'd0};
    for (int i = 10; i < 25; i++) rows[i] = '{ROW_SAMPLE, 16'h8000, 1'b0, 16'd0};
    rows[25] = '{ROW_SAMPLE, 16'h8000, 1'b1, 16'd32768};
    rows[26] = '{ROW_WINDOW, 16'd1,    1'b0, 16'd0};
    rows[27] = '{ROW_SAMPLE, 16'h0000, 1'b1, LEVEL_MAX};

    seg_win = '{8191, 3, 64, WIN_RANDOM_SMALL, 2, 4096, WIN_RANDOM_ANY, 37};
    seg_cnt = '{120, 100, 150, 150, 80, 100, 100, 150};

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_WINDOW) write_window(rows[i].value[CFG_W-1:0]);
      else push_sample(rows[i].value, rows[i].fixed, rows[i].level);
    end

    for (int s = 0; s < NUM_SEGMENTS; s++) begin
      if (s == 2) begin
        send_idle_pct = IDLE_HEAVY;
        recv_idle_pct = IDLE_LIGHT;
      end else if (s == 4) begin
        send_idle_pct = IDLE_NONE;
        recv_idle_pct = IDLE_NONE;
      end
      if (seg_win[s] == WIN_RANDOM_SMALL) w = $urandom_range(200, 1);
      else if (seg_win[s] == WIN_RANDOM_ANY) w = $urandom_range(8191);
      else w = seg_win[s];
      write_window(CFG_W'(w));
      for (int n = 0; n < seg_cnt[s]; n++) push_sample(random_sample(), 1'b0, '0);
    end

    in_tvalid <= 1'b0;
    while (pending_levels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_levels.size() != 0) begin
      $error("rms_level: %0d levels never arrived", pending_levels.size());
      fails++;
    end
    if (fails == 0) $display("tb passed");
    else $display("tb failed");
    $finish;
  end

endmodule

>>> sliding_window_rms_meter.f
+incdir+hw/rtl
hw/rtl/swrm_pkg.sv
hw/rtl/swrm_ctrl.sv
hw/rtl/swrm_dpath.sv
hw/rtl/sliding_window_rms_meter.sv
verif/tb.sv
